/* sv/cit_pkg.sv */
// ----------------------------------------------------------------------------
// Cube triangulator package
// Shared widths, payload types and the tetrahedron tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cit_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int COORD_WIDTH = 16;
    localparam int HALF_WIDTH  = 10;
    localparam int QUOT_WIDTH  = HALF_WIDTH + 1;
    localparam int NUM_WIDTH   = QUOT_WIDTH + VALUE_WIDTH;
    localparam int EXT_WIDTH   = COORD_WIDTH + HALF_WIDTH + 2;
    localparam int NUM_TETRA   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HALF_WIDTH-1:0] HALF_SIZE_RESET = HALF_WIDTH'(10);
    localparam logic [7:0] MASK_X     = 8'h66;
    localparam logic [7:0] MASK_Y     = 8'hCC;
    localparam logic [7:0] MASK_Z     = 8'hF0;
    localparam logic [7:0] ALL_INSIDE = 8'hFF;

    typedef logic [2:0] corner_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_z;
        logic signed [VALUE_WIDTH-1:0] corner_value_0;
        logic signed [VALUE_WIDTH-1:0] corner_value_1;
        logic signed [VALUE_WIDTH-1:0] corner_value_2;
        logic signed [VALUE_WIDTH-1:0] corner_value_3;
        logic signed [VALUE_WIDTH-1:0] corner_value_4;
        logic signed [VALUE_WIDTH-1:0] corner_value_5;
        logic signed [VALUE_WIDTH-1:0] corner_value_6;
        logic signed [VALUE_WIDTH-1:0] corner_value_7;
        logic                          split_select;
    } cube_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] vert_a_x;
        logic signed [COORD_WIDTH-1:0] vert_a_y;
        logic signed [COORD_WIDTH-1:0] vert_a_z;
        logic signed [COORD_WIDTH-1:0] vert_b_x;
        logic signed [COORD_WIDTH-1:0] vert_b_y;
        logic signed [COORD_WIDTH-1:0] vert_b_z;
        logic signed [COORD_WIDTH-1:0] vert_c_x;
        logic signed [COORD_WIDTH-1:0] vert_c_y;
        logic signed [COORD_WIDTH-1:0] vert_c_z;
        logic                          last_triangle;
    } tri_t;

    typedef struct packed {
        corner_t                c0;
        corner_t                c1;
        logic [VALUE_WIDTH-1:0] s0;
        logic [VALUE_WIDTH-1:0] den;
    } vjob_t;

    typedef struct packed {
        vjob_t [2:0]                   v;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic                          last;
    } job_t;

    typedef struct packed {
        logic avail;
        logic full;
    } queue_status_t;

    function automatic logic [VALUE_WIDTH-1:0] abs_value(input logic signed [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] u;
        u = v;
        return v[VALUE_WIDTH-1] ? (~u + VALUE_WIDTH'(1)) : u;
    endfunction

    function automatic logic [3:0][2:0] split_corners(input logic sel, input logic [2:0] t);
        logic [3:0][2:0] r;
        case ({sel, t})
            4'b0000: r = {3'd1, 3'd3, 3'd4, 3'd0};
            4'b0001: r = {3'd5, 3'd1, 3'd6, 3'd4};
            4'b0010: r = {3'd2, 3'd3, 3'd6, 3'd1};
            4'b0011: r = {3'd7, 3'd3, 3'd6, 3'd4};
            4'b0100: r = {3'd1, 3'd3, 3'd6, 3'd4};
            4'b1000: r = {3'd7, 3'd5, 3'd4, 3'd0};
            4'b1001: r = {3'd7, 3'd2, 3'd6, 3'd5};
            4'b1010: r = {3'd2, 3'd1, 3'd5, 3'd0};
            4'b1011: r = {3'd7, 3'd3, 3'd2, 3'd0};
            4'b1100: r = {3'd7, 3'd2, 3'd5, 3'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Each nibble is one edge: local start corner in the upper two bits.
    function automatic logic [3:0][3:0] edge_list(input logic [3:0] tb);
        logic [3:0][3:0] r;
        case (tb)
            4'd1:    r = {4'h0, 4'h1, 4'h2, 4'h3};
            4'd2:    r = {4'h0, 4'h6, 4'h7, 4'h4};
            4'd3:    r = {4'h2, 4'h6, 4'h7, 4'h3};
            4'd4:    r = {4'h0, 4'hB, 4'h8, 4'h9};
            4'd5:    r = {4'h1, 4'h9, 4'hB, 4'h3};
            4'd6:    r = {4'h4, 4'h8, 4'hB, 4'h7};
            4'd7:    r = {4'h0, 4'hB, 4'h7, 4'h3};
            4'd8:    r = {4'h0, 4'hE, 4'hD, 4'hC};
            4'd9:    r = {4'h2, 4'hE, 4'hD, 4'h1};
            4'd10:   r = {4'h6, 4'hE, 4'hC, 4'h4};
            4'd11:   r = {4'h0, 4'hE, 4'h6, 4'h2};
            4'd12:   r = {4'h9, 4'hD, 4'hC, 4'h8};
            4'd13:   r = {4'h0, 4'hD, 4'h9, 4'h1};
            4'd14:   r = {4'h0, 4'hC, 4'h8, 4'h4};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tri_count(input logic [3:0] tb);
        logic [1:0] r;
        case (tb)
            4'd0, 4'd15:                     r = 2'd0;
            4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12: r = 2'd2;
            default:                         r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/cit_front.sv */
// ----------------------------------------------------------------------------
// Cube triangulator front end
// Accepts cubes, classifies the tetrahedra and issues one triangle job a cycle while the queue is not full.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_front
    import cit_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cube_valid,
    output logic          cube_stall,
    input  cube_t         cube,
    output logic          push,
    output job_t          job,
    input  queue_status_t qstat
);

    logic                          busy_reg, busy_next;
    logic [2:0]                    tet_reg, tet_next;
    logic                          sub_reg, sub_next;
    logic [7:0]                    neg_reg;
    logic                          sel_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg [8];
    logic signed [COORD_WIDTH-1:0] cx_reg, cy_reg, cz_reg;

    logic signed [VALUE_WIDTH-1:0] in_val [8];
    logic [7:0]                    in_neg;
    logic                          accept, mixed;
    logic [3:0][2:0]               tcs [NUM_TETRA];
    logic [3:0]                    tbs [NUM_TETRA];
    logic [1:0]                    ntri [NUM_TETRA];
    logic                          later_any, last_in_tet;
    logic [1:0]                    cur_n;
    logic [3:0][3:0]               cur_e;
    logic [3:0][2:0]               cur_tc;
    logic [1:0]                    lidx [3];
    logic [3:0]                    pair;
    corner_t                       c0, c1;
    logic [VALUE_WIDTH-1:0]        a0, a1;

    assign in_val[0] = cube.corner_value_0;
    assign in_val[1] = cube.corner_value_1;
    assign in_val[2] = cube.corner_value_2;
    assign in_val[3] = cube.corner_value_3;
    assign in_val[4] = cube.corner_value_4;
    assign in_val[5] = cube.corner_value_5;
    assign in_val[6] = cube.corner_value_6;
    assign in_val[7] = cube.corner_value_7;

    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            in_neg[n] = in_val[n][VALUE_WIDTH-1];
        end
        mixed = (in_neg != 8'h00) && (in_neg != ALL_INSIDE);

        later_any = 1'b0;
        for (int t = 0; t < NUM_TETRA; t++)
        begin
            tcs[t] = split_corners(sel_reg, 3'(t));
            for (int k = 0; k < 4; k++)
            begin
                tbs[t][k] = neg_reg[tcs[t][k]];
            end
            ntri[t] = tri_count(tbs[t]);
            if ((3'(t) > tet_reg) && (ntri[t] != 2'd0))
            begin
                later_any = 1'b1;
            end
        end

        cur_n  = ntri[tet_reg];
        cur_e  = edge_list(tbs[tet_reg]);
        cur_tc = tcs[tet_reg];

        lidx[0] = {1'b0, sub_reg};
        lidx[1] = {1'b0, sub_reg} + 2'd1;
        lidx[2] = (cur_n == 2'd1) ? 2'd2 : 2'd3;

        pair = '0;
        c0   = '0;
        c1   = '0;
        a0   = '0;
        a1   = '0;
        for (int v = 0; v < 3; v++)
        begin
            pair = cur_e[lidx[v]];
            c0   = cur_tc[pair[3:2]];
            c1   = cur_tc[pair[1:0]];
            a0   = abs_value(val_reg[c0]);
            a1   = abs_value(val_reg[c1]);
            job.v[v].c0  = c0;
            job.v[v].c1  = c1;
            job.v[v].s0  = a0;
            job.v[v].den = a0 + a1;
        end
        job.cx = cx_reg;
        job.cy = cy_reg;
        job.cz = cz_reg;

        last_in_tet = (cur_n == 2'd1) || sub_reg;
        job.last    = last_in_tet && !later_any;

        push       = busy_reg && (cur_n != 2'd0) && !qstat.full;
        cube_stall = busy_reg && !(push && job.last);
        accept     = cube_valid && !cube_stall;

        busy_next = busy_reg;
        tet_next  = tet_reg;
        sub_next  = sub_reg;
        if (accept)
        begin
            busy_next = mixed;
            tet_next  = 3'd0;
            sub_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (cur_n == 2'd0)
            begin
                if (tet_reg == 3'(NUM_TETRA - 1))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    tet_next = tet_reg + 3'd1;
                end
            end
            else if (push)
            begin
                if (job.last)
                begin
                    busy_next = 1'b0;
                end
                else if (last_in_tet)
                begin
                    tet_next = tet_reg + 3'd1;
                    sub_next = 1'b0;
                end
                else
                begin
                    sub_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            tet_reg  <= 3'd0;
            sub_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            tet_reg  <= tet_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= in_neg;
            sel_reg <= cube.split_select;
            cx_reg  <= cube.center_x;
            cy_reg  <= cube.center_y;
            cz_reg  <= cube.center_z;
            for (int n = 0; n < 8; n++)
            begin
                val_reg[n] <= in_val[n];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/cit_queue.sv */
// ----------------------------------------------------------------------------
// Cube triangulator job queue
// Short FIFO of triangle jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_queue
    import cit_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          wr_job,
    input  logic          pop,
    output job_t          head,
    output queue_status_t stat
);

    job_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_reg, rd_reg;
    logic [QCNT_WIDTH-1:0] cnt_reg, cnt_next;

    assign head       = entry_reg[rd_reg];
    assign stat.avail = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == QCNT_WIDTH'(QUEUE_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_WIDTH'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_WIDTH'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_WIDTH'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

/* sv/cit_back.sv */
// ----------------------------------------------------------------------------
// Cube triangulator back end
// Pipelined edge interpolation: one multiply stage, one quotient bit per
// stage, then vertex placement with saturation into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_back
    import cit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  job_t                  head,
    input  queue_status_t         qstat,
    input  logic [HALF_WIDTH-1:0] half_size,
    output logic                  pop,
    output logic                  tri_valid,
    input  logic                  tri_stall,
    output tri_t                  triangle
);

    localparam int LAST = QUOT_WIDTH;
    localparam logic signed [EXT_WIDTH-1:0] CMAX =
        {{(EXT_WIDTH - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [EXT_WIDTH-1:0] CMIN = ~CMAX;

    typedef struct packed {
        corner_t                c0;
        corner_t                c1;
        logic [NUM_WIDTH-1:0]   rem;
        logic [VALUE_WIDTH-1:0] den;
        logic [QUOT_WIDTH-1:0]  quo;
    } dlane_t;

    typedef struct packed {
        dlane_t [2:0]                  lane;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
        logic                          last;
    } stage_t;

    stage_t st_reg   [LAST + 1];
    stage_t st_next  [LAST + 1];
    logic   vld_reg  [LAST + 1];
    logic   tri_valid_reg;
    tri_t   tri_reg, tri_next;
    logic   advance;
    logic [QUOT_WIDTH-1:0] h2;
    logic [NUM_WIDTH-1:0]  dsh;

    function automatic logic signed [COORD_WIDTH-1:0] place(
        input logic signed [COORD_WIDTH-1:0] cen,
        input logic [7:0]                    mask,
        input corner_t                       c0,
        input corner_t                       c1,
        input logic [HALF_WIDTH-1:0]         h,
        input logic [QUOT_WIDTH-1:0]         q
    );
        logic signed [EXT_WIDTH-1:0] p, hh, qq;
        logic                        b0, b1;
        b0 = mask[c0];
        b1 = mask[c1];
        p  = EXT_WIDTH'(cen);
        hh = signed'(EXT_WIDTH'(h));
        qq = signed'(EXT_WIDTH'(q));
        p  = b0 ? (p + hh) : (p - hh);
        if (b1 && !b0)
        begin
            p = p + qq;
        end
        else if (b0 && !b1)
        begin
            p = p - qq;
        end
        if (p > CMAX)
        begin
            p = CMAX;
        end
        else if (p < CMIN)
        begin
            p = CMIN;
        end
        return p[COORD_WIDTH-1:0];
    endfunction

    assign advance   = !(tri_valid_reg && tri_stall);
    assign pop       = advance && qstat.avail;
    assign tri_valid = tri_valid_reg;
    assign triangle  = tri_reg;
    assign h2        = {half_size, 1'b0};

    always_comb
    begin
        st_next[0].cx   = head.cx;
        st_next[0].cy   = head.cy;
        st_next[0].cz   = head.cz;
        st_next[0].last = head.last;
        for (int v = 0; v < 3; v++)
        begin
            st_next[0].lane[v].c0  = head.v[v].c0;
            st_next[0].lane[v].c1  = head.v[v].c1;
            st_next[0].lane[v].den = head.v[v].den;
            st_next[0].lane[v].quo = '0;
            st_next[0].lane[v].rem = NUM_WIDTH'(h2 * head.v[v].s0);
        end

        dsh = '0;
        for (int i = 1; i <= LAST; i++)
        begin
            st_next[i] = st_reg[i-1];
            for (int v = 0; v < 3; v++)
            begin
                dsh = NUM_WIDTH'(st_reg[i-1].lane[v].den) << (LAST - i);
                if (st_reg[i-1].lane[v].rem >= dsh)
                begin
                    st_next[i].lane[v].rem           = st_reg[i-1].lane[v].rem - dsh;
                    st_next[i].lane[v].quo[LAST - i] = 1'b1;
                end
            end
        end

        tri_next.vert_a_x = place(st_reg[LAST].cx, MASK_X, st_reg[LAST].lane[0].c0,
                                  st_reg[LAST].lane[0].c1, half_size, st_reg[LAST].lane[0].quo);
        tri_next.vert_a_y = place(st_reg[LAST].cy, MASK_Y, st_reg[LAST].lane[0].c0,
                                  st_reg[LAST].lane[0].c1, half_size, st_reg[LAST].lane[0].quo);
        tri_next.vert_a_z = place(st_reg[LAST].cz, MASK_Z, st_reg[LAST].lane[0].c0,
                                  st_reg[LAST].lane[0].c1, half_size, st_reg[LAST].lane[0].quo);
        tri_next.vert_b_x = place(st_reg[LAST].cx, MASK_X, st_reg[LAST].lane[1].c0,
                                  st_reg[LAST].lane[1].c1, half_size, st_reg[LAST].lane[1].quo);
        tri_next.vert_b_y = place(st_reg[LAST].cy, MASK_Y, st_reg[LAST].lane[1].c0,
                                  st_reg[LAST].lane[1].c1, half_size, st_reg[LAST].lane[1].quo);
        tri_next.vert_b_z = place(st_reg[LAST].cz, MASK_Z, st_reg[LAST].lane[1].c0,
                                  st_reg[LAST].lane[1].c1, half_size, st_reg[LAST].lane[1].quo);
        tri_next.vert_c_x = place(st_reg[LAST].cx, MASK_X, st_reg[LAST].lane[2].c0,
                                  st_reg[LAST].lane[2].c1, half_size, st_reg[LAST].lane[2].quo);
        tri_next.vert_c_y = place(st_reg[LAST].cy, MASK_Y, st_reg[LAST].lane[2].c0,
                                  st_reg[LAST].lane[2].c1, half_size, st_reg[LAST].lane[2].quo);
        tri_next.vert_c_z = place(st_reg[LAST].cz, MASK_Z, st_reg[LAST].lane[2].c0,
                                  st_reg[LAST].lane[2].c1, half_size, st_reg[LAST].lane[2].quo);
        tri_next.last_triangle = st_reg[LAST].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_valid_reg <= 1'b0;
            for (int i = 0; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            tri_valid_reg <= vld_reg[LAST];
            vld_reg[0]    <= pop;
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tri_reg <= tri_next;
            for (int i = 0; i <= LAST; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/cube_isosurface_tetra_triangulator.sv */
// ----------------------------------------------------------------------------
// Cube isosurface triangulator, marching tetrahedra
// Throughput: one triangle per cycle from the pipelined interpolator while
// tri_stall is low. A cube holds the front end while its triangles are
// issued and its empty tetrahedra skipped; a cube with no surface crossing
// is not held.
// Reset clears all control state and sets half_size to 10; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_isosurface_tetra_triangulator
    import cit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cube_valid,
    output logic                  cube_stall,
    input  cube_t                 cube,
    output logic                  tri_valid,
    input  logic                  tri_stall,
    output tri_t                  triangle,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [HALF_WIDTH-1:0] cfg_data
);

    logic [HALF_WIDTH-1:0] half_size_reg;
    logic                  push, pop;
    job_t                  wr_job, head;
    queue_status_t         qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg <= HALF_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_size_reg <= cfg_data;
        end
    end

    cit_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cube_valid (cube_valid),
        .cube_stall (cube_stall),
        .cube       (cube),
        .push       (push),
        .job        (wr_job),
        .qstat      (qstat)
    );

    cit_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .stat   (qstat)
    );

    cit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .half_size (half_size_reg),
        .pop       (pop),
        .tri_valid (tri_valid),
        .tri_stall (tri_stall),
        .triangle  (triangle)
    );

endmodule

`default_nettype wire

/* sv/cit_checker.sv */
// ----------------------------------------------------------------------------
// Cube triangulator port checker
// Watches the top-level ports for output ordering and framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module cit_checker
    import cit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cube_valid,
    input  logic                  cube_stall,
    input  logic                  tri_valid,
    input  logic                  tri_stall,
    input  tri_t                  triangle,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready
);

    logic [3:0] tri_cnt_reg;
    logic       seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_cnt_reg <= 4'd0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            if (cube_valid && !cube_stall)
            begin
                seen_reg <= 1'b1;
            end
            if (tri_valid && !tri_stall)
            begin
                tri_cnt_reg <= triangle.last_triangle ? 4'd0 : tri_cnt_reg + 4'd1;
            end
        end
    end

    // A held triangle keeps its contents.
    a_tri_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && tri_stall |=> tri_valid && $stable(triangle))
        else $error("triangle changed while stalled");

    // No cube yields more than ten triangles.
    a_tri_limit: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid && !tri_stall && (tri_cnt_reg == 4'd9) |-> triangle.last_triangle)
        else $error("more than ten triangles in one cube");

    // Triangles only appear after some cube has been taken.
    a_tri_cause: assert property (@(posedge clk) disable iff (!rst_n)
        tri_valid |-> seen_reg)
        else $error("triangle without any cube");

    // The register port never holds off a write.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind cube_isosurface_tetra_triangulator cit_checker u_cit_checker (.*);

`default_nettype wire
